### hdl/bbd_pkg.sv
// Package with the item types and register indexes of the BGGR bilinear demosaic.
package bbd_pkg;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [9:0]  FRAME_WIDTH_RESET  = 10'd316;
  localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd208;

  typedef struct packed {
    logic [7:0] raw_pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [8:0]  out_col;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } out_item_t;

endpackage

### hdl/bayer_bggr_bilinear_demosaic.sv
// Top level of the BGGR bilinear demosaic with its line memory and emission sequencer.
// The first result of an item is offered from the emission stage register once the item
// has moved on from stage one. Throughput while out_stall is low: one item per cycle while
// each item yields at most one result; an item on a border row or column yields up to
// nine results, and the single result port then sets the pace at one result per cycle.
// Reset clears the position counters, the pipeline valids and the registers to defaults;
// the line memory and the window are not cleared and need no clearing pass.
module bayer_bggr_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  // Column address width and the width that can hold the clamped frame width.
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int FWW = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
  localparam logic [FWW-1:0] MAX_W = FWW'(MAX_WIDTH);

  // Configuration registers.
  logic [9:0]  frame_width;
  logic [11:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[9:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size: the width is clamped to the range three to MAX_WIDTH, the
  // height is raised to at least three.
  logic [FWW-1:0] fw;
  logic [11:0]    fh;

  always_comb begin
    if (frame_width < 10'd3) begin
      fw = FWW'(3);
    end else if (FWW'(frame_width) > MAX_W) begin
      fw = MAX_W;
    end else begin
      fw = FWW'(frame_width);
    end
    fh = (frame_height < 12'd3) ? 12'd3 : frame_height;
  end

  // Position counters. Each accepted item first takes the pending position, then
  // resolves a frame start and any wrap left by a register change, exactly as the
  // next position is later advanced.
  logic [CW-1:0] col_count;
  logic [11:0]   row_count;
  logic [CW-1:0] pos_c;
  logic [11:0]   pos_r;
  logic [CW-1:0] col_count_next;
  logic [11:0]   row_count_next;
  logic [FWW-1:0] col_inc;

  always_comb begin
    pos_c = col_count;
    pos_r = row_count;
    if (in_data.frame_start) begin
      pos_c = '0;
      pos_r = '0;
    end
    if (FWW'(pos_c) >= fw) begin
      pos_c = '0;
      pos_r = pos_r + 12'd1;
    end
    if (pos_r >= fh) begin
      pos_r = '0;
    end
    col_inc        = FWW'(pos_c) + FWW'(1);
    col_count_next = col_inc[CW-1:0];
    row_count_next = pos_r;
    if (col_inc >= fw) begin
      col_count_next = '0;
      row_count_next = (pos_r + 12'd1 >= fh) ? 12'd0 : pos_r + 12'd1;
    end
  end

  // Pipeline handshake. Stage one holds the item whose line data is being read; it
  // moves on when it emits nothing or the emission stage can take it.
  logic          s1_valid;
  logic [7:0]    s1_raw;
  logic [CW-1:0] s1_c;
  logic [11:0]   s1_r;
  logic          s1_emit;
  logic          s1_adv;
  logic          s2_valid;
  logic          s2_free;
  logic          s2_final;
  logic          in_acc;

  assign s1_emit  = (s1_r >= 12'd2) && (s1_c >= CW'(2));
  assign s1_adv   = !s1_emit || s2_free;
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Line memory: each entry holds the byte of row r-2 (upper half) and row r-1 (lower
  // half) at one column. An item reads its column when accepted and writes it back when
  // stage one moves on, which is no later than the edge that accepts the next item.
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] mem_rd;
  logic [15:0] fwd_data;
  logic        fwd;
  logic [15:0] s1_line;
  logic [15:0] s1_wr;

  // Two items in a row can hit the same column only after a frame start; the write
  // under way is then forwarded instead of the stale read.
  assign s1_line = fwd ? fwd_data : mem_rd;
  assign s1_wr   = {s1_line[7:0], s1_raw};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_rd <= line_mem[pos_c];
    end
    if (s1_valid && s1_adv) begin
      line_mem[s1_c] <= s1_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (in_acc) begin
        s1_valid  <= 1'b1;
        col_count <= col_count_next;
        row_count <= row_count_next;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw   <= in_data.raw_pixel;
      s1_c     <= pos_c;
      s1_r     <= pos_r;
      fwd      <= s1_valid && (s1_c == pos_c);
      fwd_data <= s1_wr;
    end
  end

  // Window of the two previous columns of rows r-2, r-1 and r.
  logic [7:0] win [6];

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= s1_line[15:8];
      win[1] <= s1_line[7:0];
      win[2] <= s1_raw;
    end
  end

  // Bilinear interpolation of the centre at (r-1, c-1).
  logic [7:0]    ctr, hor, ver, crs, dia;
  logic [9:0]    sum_cross, sum_diag;
  logic [8:0]    sum_h, sum_v;
  logic [7:0]    red_c, green_c, blue_c;
  logic [11:0]   cy;
  logic [CW-1:0] cx;

  assign cy = s1_r - 12'd1;
  assign cx = s1_c - CW'(1);

  always_comb begin
    ctr       = win[1];
    sum_h     = {1'b0, win[4]} + {1'b0, s1_line[7:0]};
    sum_v     = {1'b0, win[0]} + {1'b0, win[2]};
    sum_cross = {1'b0, sum_h} + {1'b0, sum_v};
    sum_diag  = {2'b0, win[3]} + {2'b0, s1_line[15:8]} + {2'b0, win[5]} + {2'b0, s1_raw};
    hor       = sum_h[8:1];
    ver       = sum_v[8:1];
    crs       = sum_cross[9:2];
    dia       = sum_diag[9:2];
    case ({cy[0], cx[0]})
      2'b11: begin
        red_c = ctr; green_c = crs; blue_c = dia;
      end
      2'b10: begin
        red_c = hor; green_c = ctr; blue_c = ver;
      end
      2'b01: begin
        red_c = ver; green_c = ctr; blue_c = hor;
      end
      default: begin
        red_c = dia; green_c = crs; blue_c = ctr;
      end
    endcase
  end

  // Row and column lists of the positions that receive this centre's colour.
  logic [11:0]    rows_n [3];
  logic [CW-1:0]  cols_n [3];
  logic [1:0]     nr_n, nc_n;
  logic [FWW-1:0] fw_m2, fw_m1;

  always_comb begin
    fw_m2     = fw - FWW'(2);
    fw_m1     = fw - FWW'(1);
    rows_n[0] = cy;
    rows_n[1] = fh - 12'd1;
    rows_n[2] = fh - 12'd1;
    nr_n      = 2'd1;
    if (cy == 12'd1) begin
      rows_n[0] = 12'd0;
      rows_n[1] = cy;
      nr_n      = 2'd2;
    end
    if (cy == fh - 12'd2) begin
      nr_n = nr_n + 2'd1;
    end
    cols_n[0] = cx;
    cols_n[1] = fw_m1[CW-1:0];
    cols_n[2] = fw_m1[CW-1:0];
    nc_n      = 2'd1;
    if (cx == CW'(1)) begin
      cols_n[0] = '0;
      cols_n[1] = cx;
      nc_n      = 2'd2;
    end
    if (FWW'(cx) == fw_m2) begin
      nc_n = nc_n + 2'd1;
    end
  end

  // Emission stage: walks the row and column lists, one result per cycle while out_stall is low.
  logic [7:0]    s2_red, s2_green, s2_blue;
  logic [11:0]   s2_rows [3];
  logic [CW-1:0] s2_cols [3];
  logic [1:0]    s2_nr, s2_nc;
  logic [1:0]    s2_i, s2_j;
  logic          s2_last;
  logic          s2_load;

  assign s2_last  = (s2_i == s2_nr - 2'd1) && (s2_j == s2_nc - 2'd1);
  assign s2_final = s2_valid && s2_last && !out_stall;
  assign s2_free  = !s2_valid || s2_final;
  assign s2_load  = s1_valid && s1_emit && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_i     <= 2'd0;
      s2_j     <= 2'd0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
      s2_i     <= 2'd0;
      s2_j     <= 2'd0;
    end else if (s2_final) begin
      s2_valid <= 1'b0;
    end else if (s2_valid && !out_stall) begin
      if (s2_j == s2_nc - 2'd1) begin
        s2_j <= 2'd0;
        s2_i <= s2_i + 2'd1;
      end else begin
        s2_j <= s2_j + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_red   <= red_c;
      s2_green <= green_c;
      s2_blue  <= blue_c;
      s2_rows  <= rows_n;
      s2_cols  <= cols_n;
      s2_nr    <= nr_n;
      s2_nc    <= nc_n;
    end
  end

  logic [CW+8:0] col_ext;

  assign col_ext            = {9'b0, s2_cols[s2_j]};
  assign out_valid          = s2_valid;
  assign out_data.out_row   = s2_rows[s2_i];
  assign out_data.out_col   = col_ext[8:0];
  assign out_data.red       = s2_red;
  assign out_data.green     = s2_green;
  assign out_data.blue      = s2_blue;
  assign out_data.last      = s2_last;

endmodule
